// ----- rtl/assert_macros.svh -----
// Assertion macros used by the classifier RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies another in the same cycle
`define CC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check that a condition implies another in the next cycle
`define CC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/ccls_pkg.sv -----
// Types and constants of the component classifier
`default_nettype none
package ccls_pkg;

  localparam int NumW = 52;
  localparam int DivStages = NumW;
  localparam int MetaDepth = DivStages + 2;

  // round(2^32 / (2*pi)) scaled by the pico and nano factors
  localparam logic [79:0] CapScale = 80'd683565276000000000000000;
  localparam logic [49:0] IndScale = 50'd683565276000000;
  localparam logic [24:0] IndScaleLo = IndScale[24:0];
  localparam logic [24:0] IndScaleHi = IndScale[49:25];

  localparam logic [16:0] ResLimitReset = 17'd5000;
  localparam logic [16:0] ReactMinReset = 17'd30000;

  typedef enum logic {
    CfgResLimit = 1'b0,
    CfgReactMin = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CompUnknown   = 2'd0,
    CompResistor  = 2'd1,
    CompCapacitor = 2'd2,
    CompInductor  = 2'd3
  } comp_e;

  typedef struct packed {
    logic        err;
    logic        is_res;
    logic        cand;
    logic        cap_mode;
    logic        op;
    logic [31:0] r1;
    logic [19:0] f1;
  } meta_t;

endpackage
`default_nettype wire

// ----- rtl/lcr_component_classifier.sv -----
// Throughput: one word per cycle; two 52-stage restoring dividers, one bit
// per stage, set the depth. The whole pipe holds while the output word waits.
// Reset: asynchronous, active low; clears all valid bits and loads the
// phase limits with 5000 and 30000 millidegrees.
`default_nettype none
`include "assert_macros.svh"
module lcr_component_classifier import ccls_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_addr_i,
  input  wire logic [16:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // first_res, first_reactance, first_phase, first_valid, first_frequency,
  // second_res, second_reactance, second_phase, second_valid,
  // second_frequency
  input  wire logic [207:0] s_axis_tdata,
  // op
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // component_type, series_resistance, capacitance_pf, inductance_nh,
  // value_frequency, value_valid, needs_confirmation, zero fill
  output logic [159:0]      m_axis_tdata,
  // status
  output logic              m_axis_tuser
);

  logic [16:0] res_lim_q, react_min_q;
  logic        en;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_lim_q   <= ResLimitReset;
      react_min_q <= ReactMinReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CfgResLimit: res_lim_q   <= cfg_wdata_i;
        CfgReactMin: react_min_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Unpack input word
  logic        op;
  logic [31:0] r [2];
  logic [31:0] x [2];
  logic [18:0] p [2];
  logic        v [2];
  logic [19:0] f [2];
  assign op = s_axis_tuser;
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      r[l] = s_axis_tdata[104*l      +: 32];
      x[l] = s_axis_tdata[104*l + 32 +: 32];
      p[l] = s_axis_tdata[104*l + 64 +: 19];
      v[l] = s_axis_tdata[104*l + 83];
      f[l] = s_axis_tdata[104*l + 84 +: 20];
    end
  end

  // Stage 1: decode and classify by phase and resistance-reactance ratio, start the products
  logic [31:0] ax [2];
  logic [18:0] ap [2];
  logic [51:0] p0_d [2];
  logic [55:0] pl_d [2];
  logic [55:0] ph_d [2];
  meta_t       meta_d;
  logic        err0, err1, res0, cap0, ind0, res1, cand1;
  logic [31:0] rmx, rdf;
  logic signed [19:0] p1s, rmin_s;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      ax[l] = x[l][31] ? 32'(-x[l]) : x[l];
      ap[l] = p[l][18] ? 19'(-p[l]) : p[l];
      p0_d[l] = 52'(f[l]) * 52'(ax[l]);
      pl_d[l] = 56'(x[l][30:0]) * 56'(IndScaleLo);
      ph_d[l] = 56'(x[l][30:0]) * 56'(IndScaleHi);
    end
    p1s    = signed'({p[0][18], p[0]});
    rmin_s = signed'({3'b000, react_min_q});
    err0 = !v[0] || (f[0] == 20'd0);
    err1 = err0 || !v[1] || (f[1] == 20'd0) || (f[0] == f[1]);
    res0 = ({2'b00, ap[0]} <= {4'b0000, res_lim_q});
    cap0 = !res0 && (p1s <= -rmin_s) && x[0][31];
    ind0 = !res0 && !cap0 && (p1s >= rmin_s) && !x[0][31] && (x[0] != 32'd0);
    rmx  = (r[0] > r[1]) ? r[0] : r[1];
    rdf  = (r[0] > r[1]) ? r[0] - r[1] : r[1] - r[0];
    res1 = !r[0][31] && (r[0] != 32'd0) && !r[1][31] && (r[1] != 32'd0)
        && ({2'b00, ap[0]} <= {4'b0000, react_min_q})
        && ({2'b00, ap[1]} <= {4'b0000, react_min_q})
        && ({ax[0], 2'b00} <= {2'b00, r[0]})
        && ({ax[1], 2'b00} <= {2'b00, r[1]})
        && (35'(rdf) * 35'd5 <= 35'(rmx));
    cand1 = !res1 && ((x[0][31] && x[1][31]) ||
        (!x[0][31] && (x[0] != 32'd0) && !x[1][31] && (x[1] != 32'd0)));
    meta_d.err      = op ? err1 : err0;
    meta_d.is_res   = op ? res1 : res0;
    meta_d.cand     = op ? cand1 : (cap0 || ind0);
    meta_d.cap_mode = x[0][31];
    meta_d.op       = op;
    meta_d.r1       = r[0];
    meta_d.f1       = f[0];
  end

  logic [51:0] p0_q [2];
  logic [55:0] pl_q [2];
  logic [55:0] ph_q [2];
  logic [19:0] fs_q [2];
  meta_t       meta_q [MetaDepth];
  logic        vld_q  [MetaDepth];

  // Stage 2: pick divisor and rounded dividend per lane
  logic [51:0] dv_d  [2];
  logic [51:0] num_d [2];
  logic [81:0] big;
  logic [83:0] sum;
  always_comb begin
    big = '0;
    sum = '0;
    for (int l = 0; l < 2; l++) begin
      dv_d[l] = meta_q[0].cap_mode ? p0_q[l] : 52'(fs_q[l]);
      big = meta_q[0].cap_mode ? 82'(CapScale)
          : (82'(ph_q[l]) << 25) + 82'(pl_q[l]);
      sum = 84'(big) + (84'(dv_d[l]) << 31);
      num_d[l] = sum[83:32];
    end
  end

  logic [51:0] dv_q  [2];
  logic [51:0] num_q [2];

  // Divider stages: one quotient bit each
  logic [51:0] rem_q [2][DivStages];
  logic [51:0] nq_q  [2][DivStages];
  logic [51:0] dd_q  [2][DivStages];
  logic [51:0] rem_d [2][DivStages];
  logic [51:0] nq_d  [2][DivStages];
  logic [52:0] shv, dif;
  always_comb begin
    shv = '0;
    dif = '0;
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < DivStages; k++) begin
        if (k == 0) begin
          shv = {52'd0, num_q[l][51]};
          dif = shv - {1'b0, dv_q[l]};
          rem_d[l][k] = dif[52] ? shv[51:0] : dif[51:0];
          nq_d[l][k]  = {num_q[l][50:0], !dif[52]};
        end else begin
          shv = {rem_q[l][k-1], nq_q[l][k-1][51]};
          dif = shv - {1'b0, dd_q[l][k-1]};
          rem_d[l][k] = dif[52] ? shv[51:0] : dif[51:0];
          nq_d[l][k]  = {nq_q[l][k-1][50:0], !dif[52]};
        end
      end
    end
  end

  // Advance data path
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        p0_q[l]  <= p0_d[l];
        pl_q[l]  <= pl_d[l];
        ph_q[l]  <= ph_d[l];
        fs_q[l]  <= f[l];
        dv_q[l]  <= dv_d[l];
        num_q[l] <= num_d[l];
        for (int k = 0; k < DivStages; k++) begin
          rem_q[l][k] <= rem_d[l][k];
          nq_q[l][k]  <= nq_d[l][k];
          dd_q[l][k]  <= (k == 0) ? dv_q[l] : dd_q[l][(k == 0) ? 0 : k-1];
        end
      end
      meta_q[0] <= meta_d;
      for (int i = 1; i < MetaDepth; i++) meta_q[i] <= meta_q[i-1];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MetaDepth; i++) vld_q[i] <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid;
      for (int i = 1; i < MetaDepth; i++) vld_q[i] <= vld_q[i-1];
      m_axis_tvalid <= vld_q[MetaDepth-1];
    end
  end

  // Final stage: compare the two values and build the result word
  meta_t       mf;
  logic [51:0] qa, qb, qmx, qdf;
  logic        agree, take;
  comp_e       ctype;
  logic [31:0] o_res;
  logic [47:0] o_cap;
  logic [48:0] o_ind;
  logic [19:0] o_freq;
  logic        o_vv, o_needs;
  always_comb begin
    mf  = meta_q[MetaDepth-1];
    qa  = nq_q[0][DivStages-1];
    qb  = nq_q[1][DivStages-1];
    qmx = (qa > qb) ? qa : qb;
    qdf = (qa > qb) ? qa - qb : qb - qa;
    agree = (56'(qdf) * 56'd10 <= 56'(qmx));
    take = mf.cand && (!mf.op || ((qa != 52'd0) && (qb != 52'd0) && agree));
    ctype = CompUnknown; o_res = mf.r1; o_cap = '0; o_ind = '0;
    o_freq = '0; o_vv = 1'b0; o_needs = 1'b1;
    if (mf.err) begin
      o_res = '0; o_needs = 1'b0;
    end else if (mf.is_res) begin
      ctype = CompResistor; o_freq = mf.f1; o_vv = 1'b1; o_needs = 1'b0;
    end else if (take) begin
      ctype = mf.cap_mode ? CompCapacitor : CompInductor;
      o_cap = mf.cap_mode ? qa[47:0] : 48'd0;
      o_ind = mf.cap_mode ? 49'd0 : qa[48:0];
      o_freq = mf.f1; o_vv = (qa != 52'd0); o_needs = 1'b0;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tuser <= mf.err;
      m_axis_tdata <= {7'd0, o_needs, o_vv, o_freq, o_ind, o_cap, o_res, ctype};
    end
  end

  `CC_ASSERT_IMP(a_err_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 160'd0)
  `CC_ASSERT_IMP(a_cap_vv, m_axis_tvalid && (m_axis_tdata[1:0] == CompCapacitor),
                 m_axis_tdata[151] == (m_axis_tdata[81:34] != 48'd0))
  `CC_ASSERT_IMP(a_needs_unknown, m_axis_tvalid && m_axis_tdata[152],
                 (m_axis_tdata[1:0] == CompUnknown) && !m_axis_tuser)

endmodule
`default_nettype wire
